// ----- rtl/fmcr_pkg.sv -----
// ----------------------------------------------------------------------------
// fmcr_pkg
// Types, codes and packet helpers for the fingerprint module command block
// ----------------------------------------------------------------------------
package fmcr_pkg;

	typedef enum logic [1:0] {
		OP_RX   = 2'd0,
		OP_ADD  = 2'd1,
		OP_DEL  = 2'd2,
		OP_SRCH = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		PH_ARMED = 6'b000001,
		PH_TYPE  = 6'b000010,
		PH_LEN2  = 6'b000100,
		PH_LEN1  = 6'b001000,
		PH_CODE  = 6'b010000,
		PH_IDLE  = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		JOB_RX   = 3'd0,
		JOB_NF   = 3'd1,
		JOB_ADD  = 3'd2,
		JOB_DEL  = 3'd3,
		JOB_SRCH = 3'd4
	} job_kind_t;

	// packet bytes
	localparam logic [7:0] HDR0      = 8'h4D;
	localparam logic [7:0] HDR1      = 8'h58;
	localparam logic [7:0] HDR2      = 8'h10;
	localparam logic [7:0] LEN_SHORT = 8'h03;
	localparam logic [7:0] LEN_SRCH  = 8'h05;
	localparam logic [7:0] OPC_ADD   = 8'h40;
	localparam logic [7:0] OPC_DEL   = 8'h42;
	localparam logic [7:0] OPC_SRCH  = 8'h44;
	localparam logic [7:0] PAD_BYTE  = 8'h00;
	localparam logic [7:0] SRCH_ARG  = 8'h01;

	localparam logic [7:0] CKS_ADD_BASE  = 8'((HDR0 + HDR1 + HDR2 + LEN_SHORT + OPC_ADD) % 256);
	localparam logic [7:0] CKS_DEL_BASE  = 8'((HDR0 + HDR1 + HDR2 + LEN_SHORT + OPC_DEL) % 256);
	localparam logic [7:0] CKS_SRCH_BASE =
		8'((HDR0 + HDR1 + HDR2 + LEN_SRCH + OPC_SRCH + SRCH_ARG) % 256);

	// response bytes
	localparam logic [7:0] RSP_TYPE     = 8'h30;
	localparam logic [7:0] RSP_LEN1     = 8'h01;
	localparam logic [7:0] RSP_LEN2     = 8'h02;
	localparam logic [7:0] RSP_LEN4     = 8'h04;
	localparam logic [7:0] CODE_OK      = 8'h31;
	localparam logic [7:0] CODE_TIMEOUT = 8'h33;
	localparam logic [7:0] CODE_FAIL    = 8'h34;
	localparam logic [7:0] CODE_PARAM   = 8'h35;
	localparam logic [7:0] CODE_PASS    = 8'h39;
	localparam logic [7:0] CODE_DENY    = 8'h3A;

	// outcome codes
	localparam logic [2:0] OC_NONE    = 3'd0;
	localparam logic [2:0] OC_DONE    = 3'd1;
	localparam logic [2:0] OC_TIMEOUT = 3'd2;
	localparam logic [2:0] OC_FAIL    = 3'd3;
	localparam logic [2:0] OC_PASS    = 3'd4;
	localparam logic [2:0] OC_DENY    = 3'd5;
	localparam logic [2:0] OC_PARAM   = 3'd6;

	localparam logic [3:0] LAST_IDX_SHORT = 4'd7;
	localparam logic [3:0] LAST_IDX_SRCH  = 4'd9;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic       not_found;
		logic [1:0] add_outcome;
		logic [1:0] delete_outcome;
		logic [2:0] search_outcome;
		logic [7:0] result_id;
		logic [7:0] enrolled_count;
	} out_item_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [1:0] add_oc;
		logic [1:0] del_oc;
		logic [2:0] srch_oc;
		logic [7:0] id;
		logic [7:0] count;
	} job_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] oc;
	} trk_t;

	function automatic trk_t trk_step(phase_t p, logic [7:0] b, logic [7:0] opc, logic srch);
		trk_t r;
		phase_t ph;
		logic [2:0] oc;
		ph = p;
		oc = OC_NONE;
		if (b == RSP_TYPE && ph == PH_ARMED)
			ph = PH_TYPE;
		if (ph == PH_CODE) begin
			if (srch) begin
				case (b)
					CODE_OK: begin
						oc = OC_DONE;
						ph = PH_ARMED;
					end
					CODE_TIMEOUT: begin
						oc = OC_TIMEOUT;
						ph = PH_IDLE;
					end
					CODE_FAIL: begin
						oc = OC_FAIL;
						ph = PH_IDLE;
					end
					CODE_PASS: begin
						oc = OC_PASS;
						ph = PH_IDLE;
					end
					CODE_DENY: begin
						oc = OC_DENY;
						ph = PH_IDLE;
					end
					CODE_PARAM: begin
						oc = OC_PARAM;
						ph = PH_IDLE;
					end
					default: ;
				endcase
			end else begin
				case (b)
					CODE_OK:      oc = OC_DONE;
					CODE_TIMEOUT: oc = OC_TIMEOUT;
					CODE_FAIL:    oc = OC_FAIL;
					default:      oc = OC_NONE;
				endcase
				ph = PH_IDLE;
			end
		end
		if (ph == PH_LEN1)
			ph = PH_ARMED;
		if (b == opc && ph == PH_LEN2)
			ph = PH_CODE;
		if (ph == PH_TYPE && (b == RSP_LEN2 || (srch && b == RSP_LEN4)))
			ph = PH_LEN2;
		if (b == RSP_LEN1 && ph == PH_TYPE)
			ph = PH_LEN1;
		r.phase = ph;
		r.oc = oc;
		return r;
	endfunction

	function automatic logic [7:0] pkt_byte(job_kind_t kind, logic [3:0] idx, logic [7:0] id);
		logic srch;
		logic [7:0] b;
		srch = (kind == JOB_SRCH);
		case (idx)
			4'd0: b = HDR0;
			4'd1: b = HDR1;
			4'd2: b = HDR2;
			4'd3: b = srch ? LEN_SRCH : LEN_SHORT;
			4'd4: b = srch ? OPC_SRCH : ((kind == JOB_DEL) ? OPC_DEL : OPC_ADD);
			4'd5: b = PAD_BYTE;
			4'd6: b = srch ? SRCH_ARG : id;
			4'd7: begin
				if (srch)
					b = PAD_BYTE;
				else if (kind == JOB_DEL)
					b = CKS_DEL_BASE + id;
				else
					b = CKS_ADD_BASE + id;
			end
			4'd8: b = id;
			4'd9: b = CKS_SRCH_BASE + id;
			default: b = PAD_BYTE;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/fmcr_chan_if.sv -----
// ----------------------------------------------------------------------------
// fmcr_chan_if
// Valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface fmcr_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/fingerprint_module_command_response.sv -----
// ----------------------------------------------------------------------------
// fingerprint_module_command_response
// Command packet framing and response tracking for a serial fingerprint module
// ----------------------------------------------------------------------------
// A received byte gives one result transaction; received bytes can be accepted
// back to back, one per cycle, while the result output is not stalled. An add or
// delete command gives 8 result transactions and a search command 10, one per
// cycle from the packet emitter while the output is not stalled; the next item is
// taken in the cycle that the last packet byte enters the output register. A
// delete or search refused at zero count gives a single result. State updates
// (count, pending identity, trackers) happen when the item is accepted.
module fingerprint_module_command_response (
	input  logic        clk,
	input  logic        arst_n,
	fmcr_chan_if.sink   cmd,
	fmcr_chan_if.source rsp
);
	import fmcr_pkg::*;

	logic job_valid_s1;
	logic job_done;
	job_t job_s1;

	fmcr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.job_done     (job_done),
		.job_valid_s1 (job_valid_s1),
		.job_s1       (job_s1)
	);

	fmcr_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid_s1 (job_valid_s1),
		.job_s1       (job_s1),
		.job_done     (job_done),
		.rsp          (rsp)
	);

endmodule

// ----- rtl/fmcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// fmcr_ctrl
// Command decode, response trackers, enrolled count and job register
// ----------------------------------------------------------------------------
module fmcr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	fmcr_chan_if.sink     cmd,
	input  logic          job_done,
	output logic          job_valid_s1,
	output fmcr_pkg::job_t job_s1
);
	import fmcr_pkg::*;

	logic [7:0] count_q;
	logic [7:0] pending_q;
	phase_t     add_ph_q;
	phase_t     del_ph_q;
	phase_t     srch_ph_q;

	in_item_t   item;
	logic       accept;
	trk_t       add_n;
	trk_t       del_n;
	trk_t       srch_n;
	logic [7:0] cnt_a;
	logic [7:0] cnt_d;
	logic [7:0] cnt_inc;
	job_t       job_n;

	assign item       = cmd.data;
	assign cmd.ready  = !job_valid_s1 || job_done;
	assign accept     = cmd.valid && cmd.ready;

	assign add_n  = trk_step(add_ph_q, item.rx_byte, OPC_ADD, 1'b0);
	assign del_n  = trk_step(del_ph_q, item.rx_byte, OPC_DEL, 1'b0);
	assign srch_n = trk_step(srch_ph_q, item.rx_byte, OPC_SRCH, 1'b1);

	assign cnt_inc = count_q + 8'd1;
	assign cnt_a   = (add_n.oc == OC_DONE && count_q != 8'hFF) ? cnt_inc : count_q;
	assign cnt_d   = (del_n.oc == OC_DONE && cnt_a != 8'h00) ? cnt_a - 8'd1 : cnt_a;

	always_comb begin
		job_n.kind    = JOB_RX;
		job_n.add_oc  = add_n.oc[1:0];
		job_n.del_oc  = del_n.oc[1:0];
		job_n.srch_oc = srch_n.oc;
		job_n.id      = pending_q;
		job_n.count   = cnt_d;
		case (op_t'(item.op))
			OP_RX: ;
			OP_ADD: begin
				job_n.kind  = JOB_ADD;
				job_n.id    = cnt_inc;
				job_n.count = count_q;
			end
			OP_DEL, OP_SRCH: begin
				job_n.count = count_q;
				if (count_q == 8'h00) begin
					job_n.kind = JOB_NF;
				end else begin
					job_n.kind = (op_t'(item.op) == OP_DEL) ? JOB_DEL : JOB_SRCH;
					job_n.id   = count_q;
				end
			end
			default: ;
		endcase
		if (job_n.kind != JOB_RX) begin
			job_n.add_oc  = '0;
			job_n.del_oc  = '0;
			job_n.srch_oc = OC_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pending_q    <= '0;
			add_ph_q     <= PH_IDLE;
			del_ph_q     <= PH_IDLE;
			srch_ph_q    <= PH_IDLE;
			job_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				job_valid_s1 <= 1'b1;
				pending_q    <= job_n.id;
				case (job_n.kind)
					JOB_RX: begin
						count_q   <= cnt_d;
						add_ph_q  <= add_n.phase;
						del_ph_q  <= del_n.phase;
						srch_ph_q <= srch_n.phase;
					end
					JOB_ADD:  add_ph_q  <= PH_ARMED;
					JOB_DEL:  del_ph_q  <= PH_ARMED;
					JOB_SRCH: srch_ph_q <= PH_ARMED;
					default: ;
				endcase
			end else if (job_done) begin
				job_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			job_s1 <= job_n;
	end

endmodule

// ----- rtl/fmcr_tx.sv -----
// ----------------------------------------------------------------------------
// fmcr_tx
// Expands a job into registered result transactions, one per unstalled cycle
// ----------------------------------------------------------------------------
module fmcr_tx (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid_s1,
	input  fmcr_pkg::job_t job_s1,
	output logic           job_done,
	fmcr_chan_if.source    rsp
);
	import fmcr_pkg::*;

	logic [3:0] idx_q;
	logic       rsp_valid_q;
	out_item_t  rsp_data_q;

	logic       out_free;
	logic       emit;
	logic       is_pkt;
	logic       is_last;
	logic [3:0] last_idx;
	out_item_t  cur;

	assign is_pkt   = (job_s1.kind == JOB_ADD) || (job_s1.kind == JOB_DEL) ||
	                  (job_s1.kind == JOB_SRCH);
	assign last_idx = !is_pkt ? 4'd0 :
	                  ((job_s1.kind == JOB_SRCH) ? LAST_IDX_SRCH : LAST_IDX_SHORT);
	assign is_last  = (idx_q == last_idx);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign emit     = job_valid_s1 && out_free;
	assign job_done = emit && is_last;

	always_comb begin
		cur.tx_valid       = is_pkt;
		cur.tx_byte        = is_pkt ? pkt_byte(job_s1.kind, idx_q, job_s1.id) : 8'h00;
		cur.last           = is_last;
		cur.not_found      = (job_s1.kind == JOB_NF);
		cur.add_outcome    = job_s1.add_oc;
		cur.delete_outcome = job_s1.del_oc;
		cur.search_outcome = job_s1.srch_oc;
		cur.result_id      = job_s1.id;
		cur.enrolled_count = job_s1.count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
				idx_q       <= is_last ? 4'd0 : idx_q + 4'd1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			rsp_data_q <= cur;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// ----- rtl/fmcr_chk.sv -----
// ----------------------------------------------------------------------------
// fmcr_chk
// Port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
module fmcr_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input fmcr_pkg::out_item_t rsp_data
);
	import fmcr_pkg::*;

	// stalled transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// only packet bytes continue a burst
	a_burst_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.last |-> rsp_data.tx_valid && !rsp_data.not_found)
		else $error("non-last result without packet byte");

	// refusal is a lone result with no outcome
	a_nf_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.not_found |-> rsp_data.last && !rsp_data.tx_valid &&
		rsp_data.add_outcome == 2'd0 && rsp_data.delete_outcome == 2'd0 &&
		rsp_data.search_outcome == OC_NONE)
		else $error("malformed not-found result");

	// count stays fixed across a packet
	a_pkt_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_data.last |=>
		!rsp_valid || (rsp_data.enrolled_count == $past(rsp_data.enrolled_count) &&
		rsp_data.result_id == $past(rsp_data.result_id)))
		else $error("count or id changed inside a packet");

endmodule

bind fingerprint_module_command_response fmcr_chk u_fmcr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
